// File: hw/rtl/mlct_pkg.sv
// ----------------------------------------------------------------------------
// mlct_pkg
// Shared types and codes for the MESI line coherence tracker.
// ----------------------------------------------------------------------------
package mlct_pkg;

  // Default processor count sharing the line
  localparam int MAX_PROCESSORS_DEF = 8;

  // Fixed field widths
  localparam int CFG_W       = 4;
  localparam int PROC_W      = 3;
  localparam int REPORT_PROCS = 8;
  localparam int LINES_W     = 2 * REPORT_PROCS;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;

  // Reset value of processors_in_use
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_M = 2'd0,
    ST_E = 2'd1,
    ST_S = 2'd2,
    ST_I = 2'd3
  } line_st_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_BUSRD  = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_BUSRDX = 2'd3
  } bus_act_t;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_MEM   = 2'd1,
    SRC_CACHE = 2'd2,
    SRC_WRITE = 2'd3
  } data_src_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

endpackage

// File: hw/rtl/mesi_line_coherence_tracker_core.sv
// ----------------------------------------------------------------------------
// mesi_line_coherence_tracker_core
// MESI state tracker for one cache line shared by several processors.
// Path: an accepted transaction passes through the input register, then the
//   result register, which drives out_tvalid; the state update and all decisions
//   settle combinationally between them.
// Throughput: one transaction per cycle while out_tready does not stall the result register.
// Reset (rst_n low, synchronous): every line state Invalid, processor count 8,
//   both pipeline registers empty.
// ----------------------------------------------------------------------------
module mesi_line_coherence_tracker_core #(
  parameter int MAX_PROCESSORS = mlct_pkg::MAX_PROCESSORS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  // Configuration: processors_in_use
  input  logic                              cfg_wr_en,
  input  logic [mlct_pkg::CFG_W-1:0]        cfg_wr_data,

  // Bus events
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] cmd, [3:1] proc, [7:4] zero
  input  logic [mlct_pkg::IN_DATA_W-1:0]    in_tdata,

  // Results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] line_states, [17:16] bus_action, [19:18] data_source,
  // [22:20] source_cache, [23] zero
  output logic [mlct_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // Index and count widths follow the processor count
  localparam int IDX_W = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCESSORS + 1);

  // --------------------------------------------------------------------------
  // Stored state
  // --------------------------------------------------------------------------
  mlct_pkg::line_st_t                 line_st_r [MAX_PROCESSORS];
  mlct_pkg::line_st_t                 line_st_nxt [MAX_PROCESSORS];
  logic [mlct_pkg::CFG_W-1:0]         procs_cfg_r;

  // Input register
  logic                               s1_valid_r;
  mlct_pkg::cmd_t                     s1_cmd_r;
  logic [mlct_pkg::PROC_W-1:0]        s1_proc_r;

  // Result register
  logic                               out_valid_r;
  logic [mlct_pkg::LINES_W-1:0]       out_lines_r;
  mlct_pkg::bus_act_t                 out_act_r;
  mlct_pkg::data_src_t                out_src_r;
  logic [mlct_pkg::PROC_W-1:0]        out_cache_r;

  // Next result values
  logic [mlct_pkg::LINES_W-1:0]       lines_nxt;
  mlct_pkg::bus_act_t                 act_nxt;
  mlct_pkg::data_src_t                src_nxt;
  logic [mlct_pkg::PROC_W-1:0]        cache_nxt;

  // Flow control
  logic                               s1_adv;

  // Decision terms
  logic [CNT_W-1:0]                   n_eff;
  logic [MAX_PROCESSORS-1:0]          active;
  logic [MAX_PROCESSORS-1:0]          is_req;
  logic                               req_ok;
  logic                               any_valid;
  logic                               has_e;
  logic                               has_m;
  logic                               has_s;
  logic [IDX_W-1:0]                   e_idx;
  logic [IDX_W-1:0]                   m_idx;
  logic [IDX_W-1:0]                   first_s;
  logic                               m_other;
  logic                               reader_is_m;
  logic [CNT_W-1:0]                   num_s;
  mlct_pkg::line_st_t                 mid_st [MAX_PROCESSORS];

  // --------------------------------------------------------------------------
  // Handshake: advance the input register into the result register whenever
  // the result register is empty or being drained this cycle.
  // --------------------------------------------------------------------------
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  // --------------------------------------------------------------------------
  // Effective processor count: clamp zero to one and cap at MAX_PROCESSORS.
  // --------------------------------------------------------------------------
  always_comb begin
    if (procs_cfg_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(procs_cfg_r) >= MAX_PROCESSORS) begin
      n_eff = CNT_W'(MAX_PROCESSORS);
    end else begin
      n_eff = CNT_W'(procs_cfg_r);
    end
  end

  assign req_ok = (32'(s1_proc_r) < 32'(n_eff));

  // --------------------------------------------------------------------------
  // Coherence decision for the transaction held in the input register.
  // --------------------------------------------------------------------------
  always_comb begin
    any_valid = 1'b0;
    has_e     = 1'b0;
    has_m     = 1'b0;
    e_idx     = '0;
    m_idx     = '0;
    for (int i = 0; i < MAX_PROCESSORS; i++) begin
      active[i] = (i < 32'(n_eff));
      is_req[i] = (32'(s1_proc_r) == i);
      if (active[i] && line_st_r[i] != mlct_pkg::ST_I) begin
        any_valid = 1'b1;
      end
      // Highest index wins for both E and M holders
      if (active[i] && line_st_r[i] == mlct_pkg::ST_E) begin
        has_e = 1'b1;
        e_idx = IDX_W'(i);
      end
      if (active[i] && line_st_r[i] == mlct_pkg::ST_M) begin
        has_m = 1'b1;
        m_idx = IDX_W'(i);
      end
    end

    m_other     = has_m && (32'(m_idx) != 32'(s1_proc_r));
    reader_is_m = has_m && !m_other;

    // Demote a foreign M holder before the S census
    for (int i = 0; i < MAX_PROCESSORS; i++) begin
      mid_st[i] = line_st_r[i];
      if (m_other && (32'(m_idx) == i)) begin
        mid_st[i] = mlct_pkg::ST_S;
      end
    end

    // Count S holders and find the lowest one
    has_s   = 1'b0;
    num_s   = '0;
    first_s = '0;
    for (int i = 0; i < MAX_PROCESSORS; i++) begin
      if (active[i] && mid_st[i] == mlct_pkg::ST_S) begin
        if (!has_s) begin
          first_s = IDX_W'(i);
        end
        has_s = 1'b1;
        num_s = num_s + CNT_W'(1);
      end
    end

    line_st_nxt = line_st_r;
    act_nxt     = mlct_pkg::ACT_NONE;
    src_nxt     = mlct_pkg::SRC_NONE;
    cache_nxt   = '0;

    if (req_ok) begin
      if (s1_cmd_r == mlct_pkg::CMD_READ) begin
        if (!any_valid) begin
          // Cold miss: reader takes the line exclusive from memory
          for (int i = 0; i < MAX_PROCESSORS; i++) begin
            if (is_req[i]) begin
              line_st_nxt[i] = mlct_pkg::ST_E;
            end
          end
          act_nxt = mlct_pkg::ACT_BUSRD;
          src_nxt = mlct_pkg::SRC_MEM;
        end else if (has_e) begin
          // Exclusive holder flushes; holder and reader end up shared
          for (int i = 0; i < MAX_PROCESSORS; i++) begin
            if (is_req[i] || (32'(e_idx) == i)) begin
              line_st_nxt[i] = mlct_pkg::ST_S;
            end
          end
          act_nxt   = mlct_pkg::ACT_FLUSH;
          src_nxt   = mlct_pkg::SRC_CACHE;
          cache_nxt = mlct_pkg::PROC_W'(e_idx);
        end else if (!reader_is_m) begin
          line_st_nxt = mid_st;
          if (m_other) begin
            act_nxt   = mlct_pkg::ACT_BUSRD;
            src_nxt   = mlct_pkg::SRC_CACHE;
            cache_nxt = mlct_pkg::PROC_W'(m_idx);
          end
          // A partial set of sharers overrides with a flush from the lowest
          if (has_s && (num_s != n_eff)) begin
            act_nxt   = mlct_pkg::ACT_FLUSH;
            src_nxt   = mlct_pkg::SRC_CACHE;
            cache_nxt = mlct_pkg::PROC_W'(first_s);
          end
          for (int i = 0; i < MAX_PROCESSORS; i++) begin
            if (is_req[i]) begin
              line_st_nxt[i] = mlct_pkg::ST_S;
            end
          end
        end
        // Reader already Modified: hold everything
      end else begin
        // Write: invalidate every other active copy, writer goes Modified
        for (int i = 0; i < MAX_PROCESSORS; i++) begin
          if (is_req[i]) begin
            line_st_nxt[i] = mlct_pkg::ST_M;
          end else if (active[i]) begin
            line_st_nxt[i] = mlct_pkg::ST_I;
          end
        end
        act_nxt = mlct_pkg::ACT_BUSRDX;
        src_nxt = mlct_pkg::SRC_WRITE;
      end
    end

    // Pack the first eight processors; unused slots report Invalid
    for (int i = 0; i < mlct_pkg::REPORT_PROCS; i++) begin
      lines_nxt[2*i +: 2] = mlct_pkg::ST_I;
      if (i < MAX_PROCESSORS) begin
        if (i < 32'(n_eff)) begin
          lines_nxt[2*i +: 2] = line_st_nxt[i];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line state and processor count. A configuration write drops every copy.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      procs_cfg_r <= mlct_pkg::CFG_RESET;
      for (int i = 0; i < MAX_PROCESSORS; i++) begin
        line_st_r[i] <= mlct_pkg::ST_I;
      end
    end else if (cfg_wr_en) begin
      procs_cfg_r <= cfg_wr_data;
      for (int i = 0; i < MAX_PROCESSORS; i++) begin
        line_st_r[i] <= mlct_pkg::ST_I;
      end
    end else if (s1_adv) begin
      line_st_r <= line_st_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= mlct_pkg::cmd_t'(in_tdata[0]);
      s1_proc_r <= in_tdata[mlct_pkg::PROC_W:1];
    end
  end

  // --------------------------------------------------------------------------
  // Result register: load on advance, drop once taken.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_lines_r <= lines_nxt;
      out_act_r   <= act_nxt;
      out_src_r   <= src_nxt;
      out_cache_r <= cache_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cache_r, out_src_r, out_act_r, out_lines_r};

endmodule
